// ----- hw/rtl/bpa_pkg.sv -----
// Shared constants, codes and types of the bitmap page allocator.
// No dependencies; every other file but bpa_ram imports this package.
package bpa_pkg;

	// Sizing of the managed memory and the bitmap
	localparam int MAX_PAGES   = 65536;
	localparam int WORD_BITS   = 32;
	localparam int PAGE_SHIFT  = 12;
	localparam int ADDR_W      = 32;
	localparam int NWORDS      = (MAX_PAGES + WORD_BITS - 1) / WORD_BITS;
	localparam int NGROUPS     = (NWORDS + WORD_BITS - 1) / WORD_BITS;
	localparam int CNT_W       = $clog2(MAX_PAGES) + 1;
	localparam int PAGE_IDX_W  = $clog2(MAX_PAGES);
	localparam int BIT_IDX_W   = $clog2(WORD_BITS);
	localparam int WORD_IDX_W  = $clog2(NWORDS);
	localparam int GROUP_W     = $clog2(NGROUPS);
	localparam int STATUS_W    = 3;
	localparam int KIND_W      = 2;
	localparam int REG_IDX_W   = 2;

	// Item kinds
	typedef enum logic [KIND_W-1:0] {
		KIND_ALLOC = 2'd0,
		KIND_FREE  = 2'd1,
		KIND_INIT  = 2'd2
	} kind_t;

	// Result status codes
	typedef enum logic [STATUS_W-1:0] {
		ST_OK           = 3'd0,
		ST_NONE_FREE    = 3'd1,
		ST_NULL         = 3'd2,
		ST_MISALIGNED   = 3'd3,
		ST_RANGE        = 3'd4,
		ST_ALREADY_FREE = 3'd5
	} status_t;

	// Configuration register indexes
	typedef enum logic [REG_IDX_W-1:0] {
		REG_PAGE_COUNT     = 2'd0,
		REG_BASE_ADDRESS   = 2'd1,
		REG_RESERVED_PAGES = 2'd2
	} reg_index_t;

	// Configuration as seen by the core (page count already clamped)
	typedef struct packed {
		logic [CNT_W-1:0]  cnt;
		logic [ADDR_W-1:0] base;
		logic [CNT_W-1:0]  res;
	} cfg_t;

	// One result item
	typedef struct packed {
		logic [ADDR_W-1:0] addr;
		status_t           status;
		logic [CNT_W-1:0]  free;
		logic [CNT_W-1:0]  total;
	} res_t;

endpackage

// ----- hw/rtl/bpa_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module bpa_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 2048
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write port and registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ----- hw/rtl/bpa_cfg.sv -----
// Configuration register file of the page allocator.
// Depends on bpa_pkg for register indexes and the cfg_t struct.
module bpa_cfg
	import bpa_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [REG_IDX_W-1:0] cfg_index,
	input  logic [ADDR_W-1:0]    cfg_data,
	output cfg_t                 cfg
);

	logic [CNT_W-1:0]  page_count_q;
	logic [ADDR_W-1:0] base_q;
	logic [CNT_W-1:0]  reserved_q;

	assign cfg_ready = 1'b1;

	// decode writes; unknown indexes are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			page_count_q <= CNT_W'(MAX_PAGES);
			base_q       <= '0;
			reserved_q   <= CNT_W'(1);
		end else if (cfg_valid && cfg_ready) begin
			unique case (reg_index_t'(cfg_index))
				REG_PAGE_COUNT:     page_count_q <= cfg_data[CNT_W-1:0];
				REG_BASE_ADDRESS:   base_q       <= cfg_data;
				REG_RESERVED_PAGES: reserved_q   <= cfg_data[CNT_W-1:0];
				default: ;
			endcase
		end
	end

	// clamp the page count to what the bitmap holds
	always_comb begin
		cfg.cnt  = (page_count_q > CNT_W'(MAX_PAGES)) ? CNT_W'(MAX_PAGES) : page_count_q;
		cfg.base = base_q;
		cfg.res  = reserved_q;
	end

endmodule

// ----- hw/rtl/bpa_core.sv -----
// Allocation engine: free bitmap and word summary in RAM, group summary in flops.
// Depends on bpa_pkg and bpa_ram.
module bpa_core
	import bpa_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  cfg_t              cfg,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [KIND_W-1:0] kind,
	input  logic [ADDR_W-1:0] page_address,
	output logic              res_valid,
	input  logic              res_ready,
	output res_t              res
);

	typedef enum logic [5:0] {
		S_SWEEP  = 6'b000001,
		S_IDLE   = 6'b000010,
		S_A_SUM  = 6'b000100,
		S_A_LEAF = 6'b001000,
		S_F_RD   = 6'b010000,
		S_FINISH = 6'b100000
	} state_t;

	// lowest set bit of a bitmap word
	function automatic logic [BIT_IDX_W-1:0] first_bit(input logic [WORD_BITS-1:0] v);
		logic [BIT_IDX_W-1:0] idx;
		idx = '0;
		for (int i = WORD_BITS - 1; i >= 0; i--) begin
			if (v[i]) idx = BIT_IDX_W'(i);
		end
		return idx;
	endfunction

	// lowest set bit of the group summary
	function automatic logic [GROUP_W-1:0] first_group(input logic [NGROUPS-1:0] v);
		logic [GROUP_W-1:0] idx;
		idx = '0;
		for (int i = NGROUPS - 1; i >= 0; i--) begin
			if (v[i]) idx = GROUP_W'(i);
		end
		return idx;
	endfunction

	// bits below n set
	function automatic logic [WORD_BITS-1:0] mask_below(input logic [BIT_IDX_W-1:0] n);
		logic [WORD_BITS-1:0] m;
		for (int i = 0; i < WORD_BITS; i++) begin
			m[i] = (BIT_IDX_W'(i) < n);
		end
		return m;
	endfunction

	// bits of the word starting at page first that lie below page lim
	function automatic logic [WORD_BITS-1:0] span_mask(input logic [CNT_W-1:0] lim,
		input logic [CNT_W-1:0] first);
		logic [CNT_W-1:0] d;
		d = lim - first;
		if (lim <= first) return '0;
		else if (d >= CNT_W'(WORD_BITS)) return '1;
		else return mask_below(d[BIT_IDX_W-1:0]);
	endfunction

	state_t                state_q;
	logic [WORD_IDX_W-1:0] w_q;
	logic [BIT_IDX_W-1:0]  bit_q;
	logic [WORD_BITS-1:0]  acc_q;
	logic [NGROUPS-1:0]    top_q;
	logic [CNT_W-1:0]      free_count_q;
	logic [CNT_W-1:0]      sweep_cnt_q;
	logic [CNT_W-1:0]      sweep_res_q;
	logic                  reply_q;
	logic [ADDR_W-1:0]     res_addr_q;
	status_t               res_status_q;

	logic                  leaf_we, leaf_re, sum_we, sum_re;
	logic [WORD_IDX_W-1:0] leaf_waddr, leaf_raddr;
	logic [GROUP_W-1:0]    sum_waddr, sum_raddr;
	logic [WORD_BITS-1:0]  leaf_wdata, leaf_rdata, sum_wdata, sum_rdata;

	logic [GROUP_W-1:0]    w_grp;
	logic [BIT_IDX_W-1:0]  w_low;
	logic [CNT_W-1:0]      cur_first;
	logic [WORD_BITS-1:0]  sweep_word, sweep_sum;
	logic [GROUP_W-1:0]    grp_idx;
	logic [BIT_IDX_W-1:0]  k_sel;
	logic [WORD_IDX_W-1:0] cand_w;
	logic                  cand_past;
	logic [WORD_BITS-1:0]  leaf_masked, leaf_cleared, sum_cleared;
	logic [BIT_IDX_W-1:0]  j_sel;
	logic [ADDR_W-1:0]     f_off;
	logic [PAGE_IDX_W-1:0] f_page;
	logic                  f_null, f_mis, f_range, f_bad;
	logic                  bit_is_free;
	logic [WORD_BITS-1:0]  leaf_set, sum_set;
	logic [CNT_W-1:0]      init_res;

	bpa_ram #(.WIDTH(WORD_BITS), .DEPTH(NWORDS)) u_leaf (
		.clk   (clk),
		.we    (leaf_we),
		.waddr (leaf_waddr),
		.wdata (leaf_wdata),
		.re    (leaf_re),
		.raddr (leaf_raddr),
		.rdata (leaf_rdata)
	);

	bpa_ram #(.WIDTH(WORD_BITS), .DEPTH(NGROUPS)) u_sum (
		.clk   (clk),
		.we    (sum_we),
		.waddr (sum_waddr),
		.wdata (sum_wdata),
		.re    (sum_re),
		.raddr (sum_raddr),
		.rdata (sum_rdata)
	);

	// datapath terms shared by the memory controls and the state update
	always_comb begin
		w_grp       = w_q[WORD_IDX_W-1:BIT_IDX_W];
		w_low       = w_q[BIT_IDX_W-1:0];
		cur_first   = CNT_W'({w_q, {BIT_IDX_W{1'b0}}});
		sweep_word  = span_mask(sweep_cnt_q, cur_first) & ~span_mask(sweep_res_q, cur_first);
		sweep_sum   = acc_q | (WORD_BITS'(sweep_word != '0) << w_low);
		grp_idx     = first_group(top_q);
		k_sel       = first_bit(sum_rdata);
		cand_w      = {w_grp, k_sel};
		cand_past   = CNT_W'({cand_w, {BIT_IDX_W{1'b0}}}) >= cfg.cnt;
		leaf_masked = leaf_rdata & span_mask(cfg.cnt, cur_first);
		j_sel       = first_bit(leaf_masked);
		leaf_cleared = leaf_rdata & ~(WORD_BITS'(1) << j_sel);
		sum_cleared = sum_rdata & ~(WORD_BITS'(1) << w_low);
		f_off       = page_address - cfg.base;
		f_page      = f_off[PAGE_SHIFT +: PAGE_IDX_W];
		f_null      = (page_address == '0);
		f_mis       = (f_off[PAGE_SHIFT-1:0] != '0);
		f_range     = (f_off >> PAGE_SHIFT) >= ADDR_W'(cfg.cnt);
		f_bad       = f_null || f_mis || f_range;
		bit_is_free = leaf_rdata[bit_q];
		leaf_set    = leaf_rdata | (WORD_BITS'(1) << bit_q);
		sum_set     = sum_rdata | (WORD_BITS'(1) << w_low);
		init_res    = (cfg.res > cfg.cnt) ? cfg.cnt : cfg.res;
	end

	// memory controls
	always_comb begin
		leaf_we    = 1'b0;
		leaf_re    = 1'b0;
		sum_we     = 1'b0;
		sum_re     = 1'b0;
		leaf_waddr = w_q;
		leaf_raddr = w_q;
		leaf_wdata = sweep_word;
		sum_waddr  = w_grp;
		sum_raddr  = w_grp;
		sum_wdata  = sweep_sum;
		unique case (state_q)
			S_SWEEP: begin
				leaf_we = 1'b1;
				sum_we  = (w_low == BIT_IDX_W'(WORD_BITS - 1));
			end
			S_IDLE: begin
				if (in_valid) begin
					if (kind_t'(kind) == KIND_ALLOC && top_q != '0) begin
						sum_re    = 1'b1;
						sum_raddr = grp_idx;
					end else if (kind_t'(kind) == KIND_FREE && !f_bad) begin
						leaf_re    = 1'b1;
						leaf_raddr = f_page[PAGE_IDX_W-1:BIT_IDX_W];
						sum_re     = 1'b1;
						sum_raddr  = f_page[PAGE_IDX_W-1:BIT_IDX_W+GROUP_W-GROUP_W+BIT_IDX_W];
					end
				end
			end
			S_A_SUM: begin
				if (!cand_past) begin
					leaf_re    = 1'b1;
					leaf_raddr = cand_w;
				end
			end
			S_A_LEAF: begin
				if (leaf_masked != '0) begin
					leaf_we    = 1'b1;
					leaf_wdata = leaf_cleared;
					sum_we     = (leaf_cleared == '0);
					sum_wdata  = sum_cleared;
				end
			end
			S_F_RD: begin
				if (!bit_is_free) begin
					leaf_we    = 1'b1;
					leaf_wdata = leaf_set;
					sum_we     = 1'b1;
					sum_wdata  = sum_set;
				end
			end
			S_FINISH: ;
			default: ;
		endcase
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_SWEEP;
			w_q          <= '0;
			bit_q        <= '0;
			acc_q        <= '0;
			top_q        <= '0;
			free_count_q <= CNT_W'(MAX_PAGES - 1);
			sweep_cnt_q  <= CNT_W'(MAX_PAGES);
			sweep_res_q  <= CNT_W'(1);
			reply_q      <= 1'b0;
			res_addr_q   <= '0;
			res_status_q <= ST_OK;
		end else begin
			unique case (state_q)
				// rebuild one bitmap word per cycle, summary every group
				S_SWEEP: begin
					if (w_low == BIT_IDX_W'(WORD_BITS - 1)) begin
						top_q[w_grp] <= (sweep_sum != '0);
						acc_q        <= '0;
					end else begin
						acc_q <= sweep_sum;
					end
					if (w_q == WORD_IDX_W'(NWORDS - 1)) begin
						state_q <= reply_q ? S_FINISH : S_IDLE;
					end else begin
						w_q <= w_q + WORD_IDX_W'(1);
					end
				end
				// take one item and start its work
				S_IDLE: begin
					if (in_valid) begin
						res_addr_q   <= '0;
						res_status_q <= ST_OK;
						unique case (kind_t'(kind))
							KIND_ALLOC: begin
								if (top_q == '0) begin
									res_status_q <= ST_NONE_FREE;
									state_q      <= S_FINISH;
								end else begin
									w_q     <= {grp_idx, {BIT_IDX_W{1'b0}}};
									state_q <= S_A_SUM;
								end
							end
							KIND_FREE: begin
								w_q   <= f_page[PAGE_IDX_W-1:BIT_IDX_W];
								bit_q <= f_page[BIT_IDX_W-1:0];
								if (f_null) begin
									res_status_q <= ST_NULL;
									state_q      <= S_FINISH;
								end else if (f_mis) begin
									res_status_q <= ST_MISALIGNED;
									state_q      <= S_FINISH;
								end else if (f_range) begin
									res_status_q <= ST_RANGE;
									state_q      <= S_FINISH;
								end else begin
									state_q <= S_F_RD;
								end
							end
							KIND_INIT: begin
								sweep_cnt_q  <= cfg.cnt;
								sweep_res_q  <= cfg.res;
								free_count_q <= cfg.cnt - init_res;
								w_q          <= '0;
								acc_q        <= '0;
								reply_q      <= 1'b1;
								state_q      <= S_SWEEP;
							end
							default: state_q <= S_FINISH;
						endcase
					end
				end
				// pick the word within the group
				S_A_SUM: begin
					if (cand_past) begin
						res_status_q <= ST_NONE_FREE;
						state_q      <= S_FINISH;
					end else begin
						w_q     <= cand_w;
						state_q <= S_A_LEAF;
					end
				end
				// pick the page and mark it used
				S_A_LEAF: begin
					if (leaf_masked == '0) begin
						res_status_q <= ST_NONE_FREE;
					end else begin
						res_addr_q <= cfg.base +
							(ADDR_W'({w_q, j_sel}) << PAGE_SHIFT);
						if (free_count_q != '0) begin
							free_count_q <= free_count_q - CNT_W'(1);
						end
						if (leaf_cleared == '0 && sum_cleared == '0) begin
							top_q[w_grp] <= 1'b0;
						end
					end
					state_q <= S_FINISH;
				end
				// mark the page free unless it already is
				S_F_RD: begin
					if (bit_is_free) begin
						res_status_q <= ST_ALREADY_FREE;
					end else begin
						top_q[w_grp] <= 1'b1;
						if (free_count_q < CNT_W'(MAX_PAGES)) begin
							free_count_q <= free_count_q + CNT_W'(1);
						end
					end
					state_q <= S_FINISH;
				end
				// hand the result over
				S_FINISH: begin
					if (res_ready) begin
						reply_q <= 1'b0;
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign in_ready   = (state_q == S_IDLE);
	assign res_valid  = (state_q == S_FINISH);
	assign res.addr   = res_addr_q;
	assign res.status = res_status_q;
	assign res.free   = free_count_q;
	assign res.total  = cfg.cnt;

	// a set group bit always points at a nonzero summary word
	a_sum_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_A_SUM |-> sum_rdata != '0)
		else $error("group summary word empty under a set group bit");

	// an allocate or free write-back flips exactly one bitmap bit
	a_one_bit: assert property (@(posedge clk) disable iff (!arst_n)
		leaf_we && state_q != S_SWEEP |-> $countones(leaf_rdata ^ leaf_wdata) == 1)
		else $error("bitmap write-back changed other than one bit");

	// free count stays within the managed range
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		free_count_q <= CNT_W'(MAX_PAGES))
		else $error("free count above page capacity");

	// a successful allocate lowers the free count unless it was already zero
	a_alloc_count: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_A_LEAF && leaf_masked != '0 && free_count_q != '0
		|=> free_count_q == $past(free_count_q) - CNT_W'(1))
		else $error("free count not lowered on allocation");

endmodule

// ----- hw/rtl/bitmap_page_allocator_unit.sv -----
// Top level of the bitmap page allocator: config registers, core, output register.
// Depends on bpa_pkg, bpa_cfg, bpa_core (and bpa_ram through the core).
//
//  channel  direction  handshake              payload
//  in       into       in_valid / in_ready    kind, page_address
//  out      out of     out_valid / out_ready  result_address, status, free_pages, total_pages
//  cfg      into       cfg_valid / cfg_ready  cfg_index, cfg_data
//
// Allocate: summary read, bitmap read, write-back; only the summary read if the first
// free word lies past the page count, none of them if no group has a free page.
// Free: checks, bitmap read, set bit; only the checks if an address check fails. Other kinds only hand over the result.
// Reinitialize rewrites the bitmap RAM one word per cycle, then hands over its result.
// After reset the same rebuild runs with in_ready low; cfg is always ready.
// The output register frees the core, so the next item transfers while a result waits.
module bitmap_page_allocator_unit
	import bpa_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic [KIND_W-1:0]    kind,
	input  logic [ADDR_W-1:0]    page_address,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic [ADDR_W-1:0]    result_address,
	output logic [STATUS_W-1:0]  status,
	output logic [CNT_W-1:0]     free_pages,
	output logic [CNT_W-1:0]     total_pages,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [REG_IDX_W-1:0] cfg_index,
	input  logic [ADDR_W-1:0]    cfg_data
);

	cfg_t cfg;
	res_t res;
	logic res_valid, res_ready;
	logic out_valid_q;
	res_t out_q;

	bpa_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	bpa_core u_core (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.kind         (kind),
		.page_address (page_address),
		.res_valid    (res_valid),
		.res_ready    (res_ready),
		.res          (res)
	);

	// load the output register when empty or drained this cycle
	assign res_ready = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_ready) begin
			out_valid_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_ready && res_valid) begin
			out_q <= res;
		end
	end

	assign out_valid      = out_valid_q;
	assign result_address = out_q.addr;
	assign status         = out_q.status;
	assign free_pages     = out_q.free;
	assign total_pages    = out_q.total;

endmodule

// ----- tb/tb_bitmap_page_allocator_unit.sv -----
// Self-checking testbench for bitmap_page_allocator_unit: directed and random
// allocate/free/init traffic checked against a bit-level page map predictor.
// Depends on bpa_pkg and the allocator RTL only.
`timescale 1ns / 1ps

import bpa_pkg::*;

// Page map predictor plus the queue of results it expects from the block
class page_map_scoreboard;
	logic [CNT_W-1:0]  page_count_reg;
	logic [ADDR_W-1:0] base_reg;
	logic [CNT_W-1:0]  reserved_reg;
	bit                free_map [MAX_PAGES];
	logic [CNT_W-1:0]  free_total;
	res_t              expected_q [$];
	int                errors;

	function new();
		page_count_reg = CNT_W'(MAX_PAGES);
		base_reg       = '0;
		reserved_reg   = CNT_W'(1);
		errors         = 0;
		rebuild_map();
	endfunction

	// Pages actually managed: the register clamped to the map size
	function logic [CNT_W-1:0] live_pages();
		logic [CNT_W-1:0] lim;
		lim = CNT_W'(MAX_PAGES);
		return (page_count_reg > lim) ? lim : page_count_reg;
	endfunction

	function logic [ADDR_W-1:0] page_address_of(int unsigned page);
		return base_reg + (page << PAGE_SHIFT);
	endfunction

	// Reserved low pages used, the rest below the count free, all above used
	function void rebuild_map();
		int unsigned      p;
		logic [CNT_W-1:0] cnt;
		logic [CNT_W-1:0] held;
		cnt  = live_pages();
		held = (reserved_reg > cnt) ? cnt : reserved_reg;
		for (p = 0; p < MAX_PAGES; p++)
			free_map[PAGE_IDX_W'(p)] = (p >= held) && (p < cnt);
		free_total = cnt - held;
	endfunction

	function void write_reg(logic [REG_IDX_W-1:0] idx, logic [ADDR_W-1:0] data);
		case (idx)
			REG_PAGE_COUNT:     page_count_reg = data[CNT_W-1:0];
			REG_BASE_ADDRESS:   base_reg       = data;
			REG_RESERVED_PAGES: reserved_reg   = data[CNT_W-1:0];
			default: ;
		endcase
	endfunction

	// Apply one transferred item to the map and queue the result it must produce
	function void note_item(logic [KIND_W-1:0] k, logic [ADDR_W-1:0] a);
		res_t              r;
		logic [CNT_W-1:0]  cnt;
		logic [ADDR_W-1:0] offset;
		logic [ADDR_W-1:0] page;
		int unsigned       p;
		cnt      = live_pages();
		r.addr   = '0;
		r.status = ST_OK;
		case (k)
			KIND_ALLOC: begin
				r.status = ST_NONE_FREE;
				for (p = 0; p < cnt; p++) begin
					if (free_map[PAGE_IDX_W'(p)]) begin
						free_map[PAGE_IDX_W'(p)] = 1'b0;
						if (free_total != 0)
							free_total = free_total - CNT_W'(1);
						r.addr   = page_address_of(p);
						r.status = ST_OK;
						break;
					end
				end
			end
			KIND_FREE: begin
				offset = a - base_reg;
				page   = offset >> PAGE_SHIFT;
				if (a == '0)
					r.status = ST_NULL;
				else if (offset[PAGE_SHIFT-1:0] != '0)
					r.status = ST_MISALIGNED;
				else if (page >= cnt)
					r.status = ST_RANGE;
				else if (free_map[page[PAGE_IDX_W-1:0]])
					r.status = ST_ALREADY_FREE;
				else begin
					free_map[page[PAGE_IDX_W-1:0]] = 1'b1;
					if (free_total < MAX_PAGES)
						free_total = free_total + CNT_W'(1);
				end
			end
			KIND_INIT: rebuild_map();
			default: ;
		endcase
		r.free  = free_total;
		r.total = cnt;
		expected_q.push_back(r);
	endfunction

	function int pending();
		return expected_q.size();
	endfunction

	// Random page in the low window of the map with the wanted state
	function bit pick_page(bit want_free, output int unsigned page);
		int unsigned window;
		window = (live_pages() < 256) ? live_pages() : 256;
		page   = 0;
		if (window == 0)
			return 1'b0;
		repeat (8) begin
			page = $urandom_range(0, window - 1);
			if (free_map[PAGE_IDX_W'(page)] == want_free)
				return 1'b1;
		end
		return 1'b0;
	endfunction

	task report(string field, logic [ADDR_W-1:0] got, logic [ADDR_W-1:0] want);
		$display("%0t: %s mismatch, got %0h want %0h", $time, field, got, want);
		errors++;
	endtask

	// Compare one transferred result with the oldest expectation
	task check_result(logic [ADDR_W-1:0] addr, logic [STATUS_W-1:0] st,
			logic [CNT_W-1:0] fr, logic [CNT_W-1:0] tot);
		res_t want;
		if (expected_q.size() == 0) begin
			report("unexpected result", addr, '0);
			return;
		end
		want = expected_q.pop_front();
		if (addr !== want.addr)
			report("result_address", addr, want.addr);
		if (st !== want.status)
			report("status", ADDR_W'(st), ADDR_W'(want.status));
		if (fr !== want.free)
			report("free_pages", ADDR_W'(fr), ADDR_W'(want.free));
		if (tot !== want.total)
			report("total_pages", ADDR_W'(tot), ADDR_W'(want.total));
	endtask
endclass

module tb_bitmap_page_allocator_unit;
	localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;
	localparam int ITEM_TARGET = 1400;
	localparam int HOLD_CYCLES = 400;
	localparam int STALL_LIMIT = 12000;
	localparam int DRAIN_CYCLES = 8;

	logic                 clk;
	logic                 arst_n;
	logic                 in_valid;
	logic                 in_ready;
	logic [KIND_W-1:0]    kind;
	logic [ADDR_W-1:0]    page_address;
	logic                 out_valid;
	logic                 out_ready;
	logic [ADDR_W-1:0]    result_address;
	logic [STATUS_W-1:0]  status;
	logic [CNT_W-1:0]     free_pages;
	logic [CNT_W-1:0]     total_pages;
	logic                 cfg_valid;
	logic                 cfg_ready;
	logic [REG_IDX_W-1:0] cfg_index;
	logic [ADDR_W-1:0]    cfg_data;

	page_map_scoreboard sb;
	bit                 hold_request;
	bit                 hold_done;
	bit                 sender_no_idle;
	int                 idle_cycles;

	bitmap_page_allocator_unit dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .kind(kind), .page_address(page_address),
		.out_valid(out_valid), .out_ready(out_ready), .result_address(result_address),
		.status(status), .free_pages(free_pages), .total_pages(total_pages),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always begin
		clk = 1'b0;
		#6;
		clk = 1'b1;
		#6;
	end

	// Mostly short gaps, now and then a long one
	function automatic int pick_gap(bit no_idle);
		int r;
		if (no_idle)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		if (r < 98)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	// Free addresses: mostly pages in use, the rest aimed at each error check
	function automatic logic [ADDR_W-1:0] pick_free_address();
		int unsigned       r;
		int unsigned       p;
		int unsigned       cnt;
		logic [ADDR_W-1:0] a;
		bit                found;
		cnt   = 32'(sb.live_pages());
		r     = $urandom_range(0, 99);
		found = 1'b0;
		p     = 0;
		if (r < 60)
			found = sb.pick_page(1'b0, p);
		else if (r < 72)
			found = sb.pick_page(1'b1, p);
		if (!found && cnt != 0)
			p = $urandom_range(0, cnt - 1);
		a = sb.page_address_of(p);
		if (r >= 72 && r < 80)
			a = a + $urandom_range(1, (1 << PAGE_SHIFT) - 1);
		else if (r >= 80 && r < 88)
			a = sb.page_address_of($urandom_range(cnt, 20'hFFFFF));
		else if (r >= 88 && r < 92)
			a = '0;
		else if (r >= 92)
			a = $urandom();
		return a;
	endfunction

	// Offer one item after a random gap and hold it until transferred
	task send_item(input logic [KIND_W-1:0] k, input logic [ADDR_W-1:0] a);
		int gap;
		gap = pick_gap(sender_no_idle);
		if (gap > 0) begin
			in_valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid     = 1'b1;
		kind         = k;
		page_address = a;
		do @(posedge clk); while (!in_ready);
		@(negedge clk);
	endtask

	// Stop offering and wait until every expected result has come back
	task drain();
		in_valid = 1'b0;
		while (sb.pending() != 0)
			@(negedge clk);
	endtask

	task put_reg(input logic [REG_IDX_W-1:0] idx, input logic [ADDR_W-1:0] data);
		cfg_valid = 1'b1;
		cfg_index = idx;
		cfg_data  = data;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
	endtask

	// Write the registers selected in which, bit i for register index i
	task configure(input logic [CNT_W-1:0] pc, input logic [ADDR_W-1:0] base,
			input logic [CNT_W-1:0] rp, input logic [2:0] which);
		if (which[0])
			put_reg(REG_PAGE_COUNT, ADDR_W'(pc));
		if (which[1])
			put_reg(REG_BASE_ADDRESS, base);
		if (which[2])
			put_reg(REG_RESERVED_PAGES, ADDR_W'(rp));
		cfg_valid = 1'b0;
	endtask

	// Record every transfer on the three channels
	always @(posedge clk) begin
		if (cfg_valid && cfg_ready)
			sb.write_reg(cfg_index, cfg_data);
		if (in_valid && in_ready)
			sb.note_item(kind, page_address);
		if (out_valid && out_ready)
			sb.check_result(result_address, status, free_pages, total_pages);
	end

	// End the run when nothing has transferred for too long
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
			idle_cycles <= 0;
		else begin
			idle_cycles <= idle_cycles + 1;
			if (idle_cycles == STALL_LIMIT) begin
				$display("Verification failed");
				$finish;
			end
		end
	end

	// Receiver: random ready stretches and gaps, one long hold-off on request
	initial begin
		int gap;
		hold_done = 1'b0;
		forever begin
			if (hold_request && !hold_done) begin
				out_ready = 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
				hold_done = 1'b1;
			end else begin
				out_ready = 1'b1;
				repeat ($urandom_range(1, ($urandom_range(0, 4) == 0) ? 200 : 12))
					@(negedge clk);
				gap = pick_gap(1'b0);
				if (gap > 0) begin
					out_ready = 1'b0;
					repeat (gap) @(negedge clk);
				end
			end
		end
	end

	initial begin
		int unsigned      items_sent;
		int unsigned      phase;
		int unsigned      phase_len;
		int unsigned      i;
		int unsigned      r;
		logic [CNT_W-1:0] pc;
		logic [CNT_W-1:0] rp;
		logic [ADDR_W-1:0] base;
		bit               init_first;

		sb             = new();
		arst_n         = 1'b0;
		in_valid       = 1'b0;
		kind           = KIND_ALLOC;
		page_address   = '0;
		cfg_valid      = 1'b0;
		cfg_index      = REG_PAGE_COUNT;
		cfg_data       = '0;
		hold_request   = 1'b0;
		sender_no_idle = 1'b0;
		repeat (10) @(negedge clk);
		arst_n = 1'b1;

		// Reset map: page zero reserved, one free check of each kind
		send_item(KIND_ALLOC, 32'h0);
		send_item(KIND_ALLOC, 32'hFFFF_FFFF);
		send_item(KIND_FREE, 32'h0000_1000);
		send_item(KIND_FREE, 32'h0000_1000);
		send_item(KIND_FREE, 32'h0000_0000);
		send_item(KIND_FREE, 32'h0000_1234);
		send_item(KIND_FREE, 32'hFFFF_F000);
		send_item(KIND_UNUSED, 32'hFFFF_FFFF);
		send_item(KIND_FREE, 32'h0000_2000);

		// Four pages near the top of the address space: addresses wrap
		drain();
		configure(4, 32'hFFFF_E000, 0, 3'b111);
		send_item(KIND_INIT, 32'h0);
		repeat (5) send_item(KIND_ALLOC, 32'h0);
		send_item(KIND_FREE, 32'h0000_0000);
		send_item(KIND_FREE, 32'hFFFF_F001);
		send_item(KIND_FREE, 32'h0000_2000);
		send_item(KIND_FREE, 32'hFFFF_E000);

		// Count above the map size, every page reserved
		drain();
		configure(17'h1FFFF, 32'h0, 17'h10000, 3'b111);
		send_item(KIND_INIT, 32'h0);
		send_item(KIND_ALLOC, 32'h0);
		send_item(KIND_FREE, 32'h0000_5000);

		// Page count zero: nothing to allocate, every free out of range
		drain();
		configure(0, 32'h1234_5000, 0, 3'b011);
		send_item(KIND_ALLOC, 32'h0);
		send_item(KIND_FREE, 32'h1234_5000);

		// Shrink the count without init: free pages above it stay hidden
		drain();
		configure(8, 32'h0, 2, 3'b101);
		send_item(KIND_INIT, 32'h0);
		drain();
		configure(3, 32'h0, 0, 3'b001);
		send_item(KIND_ALLOC, 32'h0);
		send_item(KIND_ALLOC, 32'h0);
		send_item(KIND_FREE, 32'h1234_A000);

		// Random phases, each under a fresh configuration
		items_sent = 0;
		phase      = 0;
		while (items_sent < ITEM_TARGET) begin
			drain();
			r = $urandom_range(0, 9);
			if (r == 0)
				pc = 1;
			else if (r < 6)
				pc = CNT_W'($urandom_range(2, 48));
			else if (r < 8)
				pc = CNT_W'(MAX_PAGES);
			else if (r == 8)
				pc = CNT_W'($urandom_range(49, MAX_PAGES - 1));
			else
				pc = CNT_W'($urandom_range(MAX_PAGES + 1, 17'h1FFFF));
			case ($urandom_range(0, 7))
				0: base = 32'h0;
				1: base = 32'hFFFF_F000;
				2: base = 32'hFFFF_FFFF;
				3: base = $urandom();
				default: base = $urandom() & 32'hFFFF_F000;
			endcase
			if (pc <= 48)
				rp = CNT_W'($urandom_range(0, pc + 4));
			else
				rp = ($urandom_range(0, 3) == 0) ? '0 : CNT_W'($urandom_range(1, 40));
			init_first = (phase == 0) || ($urandom_range(0, 5) != 0);
			configure(pc, base, rp, init_first ? 3'b111 : 3'b001);
			sender_no_idle = (phase == 0) || ($urandom_range(0, 3) == 0);
			phase_len = (phase == 0) ? 150 : $urandom_range(20, 80);
			if (init_first) begin
				send_item(KIND_INIT, $urandom());
				items_sent++;
			end
			// First phase: stall the receiver while items keep coming
			if (phase == 0)
				hold_request = 1'b1;
			for (i = 0; i < phase_len; i++) begin
				r = $urandom_range(0, 99);
				if (r < 50)
					send_item(KIND_ALLOC, $urandom());
				else if (r < 93)
					send_item(KIND_FREE, pick_free_address());
				else if (r < 96)
					send_item(KIND_INIT, $urandom());
				else
					send_item(KIND_UNUSED, $urandom());
			end
			items_sent += phase_len;
			phase++;
		end

		drain();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (sb.errors == 0 && sb.pending() == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end
endmodule

// ----- files.f -----
hw/rtl/bpa_pkg.sv
hw/rtl/bpa_ram.sv
hw/rtl/bpa_cfg.sv
hw/rtl/bpa_core.sv
hw/rtl/bitmap_page_allocator_unit.sv
tb/tb_bitmap_page_allocator_unit.sv
